@@ rtl/wsd_pkg.sv @@
// Package for the WebSocket frame deframer.
// Holds the parser phase codes, header constants and the result beat type.
// No dependencies.
package wsd_pkg;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  localparam int LEN_W = 63;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last;
    logic       truncated;
    logic       empty_res;
  } result_t;

endpackage

@@ rtl/wsd_parser.sv @@
// Frame header walker and payload unmasking for the WebSocket deframer.
// Depends on wsd_pkg. Produces at most one result beat per accepted byte.
module wsd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic [15:0]     max_payload,
  output logic            res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  phase_t             phase, phase_next;
  logic [3:0]         opcode_reg, opcode_reg_next;
  logic               fin_reg, fin_reg_next;
  logic               masked_reg, masked_reg_next;
  logic [2:0]         ext_cnt, ext_cnt_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [31:0]        mask_key, mask_key_next;
  logic [15:0]        pos, pos_next;

  logic [LEN_W-1:0]   len_cand;
  logic               hdr_end;
  logic [15:0]        keep;
  logic [16:0]        pos_inc;
  logic               at_keep;
  logic               rem_one;
  logic [7:0]         key_byte;

  assign keep    = (max_payload == 16'd0) ? 16'd1 : max_payload;
  assign pos_inc = {1'b0, pos} + 17'd1;
  assign at_keep = (pos_inc == {1'b0, keep});
  assign rem_one = (remaining == LEN_W'(1));

  always_comb begin
    unique case (pos[1:0])
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next      = phase;
    opcode_reg_next = opcode_reg;
    fin_reg_next    = fin_reg;
    masked_reg_next = masked_reg;
    ext_cnt_next    = ext_cnt;
    remaining_next  = remaining;
    mask_key_next   = mask_key;
    pos_next        = pos;
    len_cand        = remaining;
    hdr_end         = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    res.frame_opcode   = opcode_reg;
    res.final_fragment = fin_reg;

    unique case (phase)
      PH_HDR1: begin
        masked_reg_next = rx_byte[7];
        if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
          ext_cnt_next   = (rx_byte[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
          remaining_next = '0;
          phase_next     = PH_EXT;
        end else begin
          len_cand = LEN_W'(rx_byte[6:0]);
          remaining_next = len_cand;
          if (rx_byte[7]) begin
            phase_next    = PH_KEY;
            ext_cnt_next  = KEY_CNT;
            mask_key_next = '0;
          end else begin
            hdr_end = 1'b1;
          end
        end
      end
      PH_EXT: begin
        len_cand       = {remaining[LEN_W-9:0], rx_byte};
        remaining_next = len_cand;
        if (ext_cnt != 3'd0) begin
          ext_cnt_next = ext_cnt - 3'd1;
        end else if (masked_reg) begin
          phase_next    = PH_KEY;
          ext_cnt_next  = KEY_CNT;
          mask_key_next = '0;
        end else begin
          hdr_end = 1'b1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (ext_cnt != 3'd0) begin
          ext_cnt_next = ext_cnt - 3'd1;
        end else begin
          hdr_end = 1'b1;
        end
      end
      PH_DATA: begin
        if ({1'b0, pos} < {1'b0, keep}) begin
          res_valid      = 1'b1;
          res.data_byte  = rx_byte ^ (masked_reg ? key_byte : 8'd0);
          res.last       = rem_one || at_keep;
          res.truncated  = at_keep && !rem_one;
        end
        pos_next       = (pos == 16'hFFFF) ? pos : pos_inc[15:0];
        remaining_next = remaining - LEN_W'(1);
        if (rem_one) phase_next = PH_HDR0;
      end
      default: begin
        fin_reg_next    = rx_byte[7];
        opcode_reg_next = rx_byte[3:0];
        phase_next      = PH_HDR1;
      end
    endcase

    if (hdr_end) begin
      pos_next = '0;
      if (len_cand == '0) begin
        phase_next    = PH_HDR0;
        res_valid     = 1'b1;
        res.last      = 1'b1;
        res.empty_res = 1'b1;
      end else begin
        phase_next = PH_DATA;
      end
    end

    if (!accept) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      opcode_reg <= '0;
      fin_reg    <= 1'b0;
      masked_reg <= 1'b0;
      ext_cnt    <= '0;
      remaining  <= '0;
      mask_key   <= '0;
      pos        <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      opcode_reg <= opcode_reg_next;
      fin_reg    <= fin_reg_next;
      masked_reg <= masked_reg_next;
      ext_cnt    <= ext_cnt_next;
      remaining  <= remaining_next;
      mask_key   <= mask_key_next;
      pos        <= pos_next;
    end
  end

endmodule

@@ rtl/wsd_out_buf.sv @@
// Output register with skid stage for the deframer result channel.
// Depends on wsd_pkg for the result beat type.
module wsd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_data
);
  import wsd_pkg::*;

  result_t main_data, skid_data;
  logic    main_valid, skid_valid;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_data <= skid_data;
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket (RFC 6455) receive deframer: takes one byte per clock and emits
// unmasked payload beats tagged with opcode, FIN, last, truncated and empty.
// A byte is accepted every clock while in_stall is low; its result, if any,
// is registered in the output stage and presented from it. A two-deep output
// stage (register plus skid) raises in_stall only when two results wait, so
// the sustained rate is one byte per cycle with no downstream stall. Header
// bytes and payload bytes past max_payload (1 if zero) produce no
// beat; a zero-length frame gives a single empty beat when its header ends.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode,
  output logic        final_fragment,
  output logic        last,
  output logic        truncated,
  output logic        empty_res
);
  import wsd_pkg::*;

  logic [15:0] max_payload;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  assign accept = in_valid && !in_stall;

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign data_byte      = out_data.data_byte;
  assign frame_opcode   = out_data.frame_opcode;
  assign final_fragment = out_data.final_fragment;
  assign last           = out_data.last;
  assign truncated      = out_data.truncated;
  assign empty_res      = out_data.empty_res;

endmodule

@@ rtl/wsd_checker.sv @@
// Port-level checks for websocket_frame_deframer.
// Bound to the top level; sees only its ports.
module wsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic [3:0] frame_opcode,
  input logic       final_fragment,
  input logic       last,
  input logic       truncated,
  input logic       empty_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) &&
      $stable(frame_opcode) && $stable(final_fragment) && $stable(last) &&
      $stable(truncated) && $stable(empty_res))
    else $error("stalled result beat changed");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && !truncated && data_byte == 8'd0)
    else $error("empty beat malformed");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> last && !empty_res)
    else $error("truncated beat not last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .data_byte      (data_byte),
  .frame_opcode   (frame_opcode),
  .final_fragment (final_fragment),
  .last           (last),
  .truncated      (truncated),
  .empty_res      (empty_res)
);

@@ bench/websocket_frame_deframer_test.sv @@
// Self-checking bench for websocket_frame_deframer: byte stream of WebSocket frames in,
// unmasked payload beats out, each compared against an in-bench frame parser.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module websocket_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 120;

  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic [3:0]  frame_opcode;
  logic        final_fragment;
  logic        last;
  logic        truncated;
  logic        empty_res;

  websocket_frame_deframer uut (.*);

  // parser state
  phase_t      ph = PH_HDR0;
  logic [3:0]  op_f = '0;
  logic        fin_f = 1'b0;
  logic        masked_f = 1'b0;
  logic [2:0]  ext_left = '0;
  logic [62:0] frame_len = '0;
  logic [31:0] key_f = '0;
  logic [62:0] pos_f = '0;
  logic [15:0] cap_setting = MAX_PAYLOAD_RST;

  logic [7:0] rx_stream [$];
  logic [7:0] opening [$];
  result_t    beats_due [$];
  result_t    got, want;
  int         mismatches = 0;
  int         cycles = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         stall_span = 0;
  int         stall_pct = 0;
  int         hold_left = 0;
  logic       hold_kick = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic header_complete();
    pos_f = '0;
    if (frame_len == 0) begin
      ph = PH_HDR0;
      beats_due.push_back({8'h00, op_f, fin_f, 1'b1, 1'b0, 1'b1});
    end else begin
      ph = PH_DATA;
    end
  endtask

  task automatic length_known();
    if (masked_f) begin
      ph = PH_KEY;
      ext_left = KEY_CNT;
      key_f = '0;
    end else begin
      header_complete();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [62:0] keep;
    logic [7:0]  kb;
    logic        last_b;
    case (ph)
      PH_HDR1: begin
        masked_f = b[7];
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ext_left = (b[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
          frame_len = '0;
          ph = PH_EXT;
        end else begin
          frame_len = {56'd0, b[6:0]};
          length_known();
        end
      end
      PH_EXT: begin
        frame_len = {frame_len[54:0], b};
        if (ext_left != 0) ext_left--;
        else length_known();
      end
      PH_KEY: begin
        key_f = {key_f[23:0], b};
        if (ext_left != 0) ext_left--;
        else header_complete();
      end
      PH_DATA: begin
        keep = (cap_setting == 0) ? 63'd1 : {47'd0, cap_setting};
        if (pos_f < keep) begin
          kb = masked_f ? key_f[8 * (3 - pos_f[1:0]) +: 8] : 8'h00;
          last_b = (pos_f + 1 == frame_len) || (pos_f + 1 == keep);
          beats_due.push_back({b ^ kb, op_f, fin_f, last_b, last_b && (frame_len > keep), 1'b0});
        end
        pos_f = pos_f + 1;
        if (pos_f >= frame_len) ph = PH_HDR0;
      end
      default: begin
        fin_f = b[7];
        op_f = b[3:0];
        ph = PH_HDR1;
      end
    endcase
  endtask

  task automatic send_frame(input int len, input logic masked, input len_form_t form);
    logic [31:0] key;
    logic [15:0] l16;
    l16 = len[15:0];
    key = $urandom;
    rx_stream.push_back($urandom_range(0, 255));
    case (form)
      FORM_7: rx_stream.push_back({masked, l16[6:0]});
      FORM_16: begin
        rx_stream.push_back({masked, LEN_EXT16});
        rx_stream.push_back(l16[15:8]);
        rx_stream.push_back(l16[7:0]);
      end
      default: begin
        rx_stream.push_back({masked, LEN_EXT64});
        rx_stream.push_back({1'($urandom_range(0, 1)), 7'd0});
        repeat (5) rx_stream.push_back(8'h00);
        rx_stream.push_back(l16[15:8]);
        rx_stream.push_back(l16[7:0]);
      end
    endcase
    if (masked) begin
      rx_stream.push_back(key[31:24]);
      rx_stream.push_back(key[23:16]);
      rx_stream.push_back(key[15:8]);
      rx_stream.push_back(key[7:0]);
    end
    repeat (len) rx_stream.push_back($urandom_range(0, 255));
  endtask

  task automatic random_frames(input int nbytes);
    int start;
    int cap;
    int len;
    len_form_t form;
    start = rx_stream.size();
    cap = (cap_setting == 0) ? 1 : cap_setting;
    while (rx_stream.size() - start < nbytes) begin
      case ($urandom_range(0, 11))
        0: len = 0;
        1: len = (cap <= 300) ? cap : $urandom_range(1, 24);
        2: len = (cap <= 300) ? cap + $urandom_range(1, 5) : $urandom_range(1, 24);
        3: len = (cap >= 2 && cap <= 300) ? cap - 1 : $urandom_range(1, 24);
        4: len = $urandom_range(126, 260);
        default: len = $urandom_range(1, 24);
      endcase
      if (len >= 126) form = ($urandom_range(0, 1) == 0) ? FORM_16 : FORM_64;
      else case ($urandom_range(0, 6))
        0: form = FORM_16;
        1: form = FORM_64;
        default: form = FORM_7;
      endcase
      send_frame(len, 1'($urandom_range(0, 1)), form);
    end
  endtask

  task automatic settle();
    while (rx_stream.size() != 0 || in_valid || beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cap(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cap_setting = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // byte driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= rx_stream.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      stall_span--;
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // beat checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {data_byte, frame_opcode, final_fragment, last, truncated, empty_res};
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = beats_due.pop_front();
        if (got.data_byte !== want.data_byte || got.frame_opcode !== want.frame_opcode ||
            got.final_fragment !== want.final_fragment || got.last !== want.last ||
            got.truncated !== want.truncated || got.empty_res !== want.empty_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [15:0] caps [$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // rsv bits set; empty masked frame; 16-bit length; 64-bit length with top bit set
    opening = '{8'hF1, 8'h02, 8'h00, 8'hFF,
                8'h8A, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
                8'h02, 8'h7E, 8'h00, 8'h03, 8'hA5, 8'h5A, 8'hC3,
                8'h80, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h7F};
    foreach (opening[i]) rx_stream.push_back(opening[i]);
    settle();
    caps = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'($urandom_range(2, 40)),
             16'($urandom_range(2, 40)), MAX_PAYLOAD_RST, 16'($urandom_range(41, 65534))};
    foreach (caps[i]) begin
      set_cap(caps[i]);
      random_frames(PHASE_BYTES);
      if (i == 4) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      settle();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("websocket_frame_deframer_test OK");
    end else begin
      $display("websocket_frame_deframer_test NOT OK");
    end
    $finish;
  end

endmodule
